FILE: rtl/core/csv_quoted_field_tokenizer_core_assert.svh
// ----------------------------------------------------------------------------
// CSV tokenizer assertion macros
// Shared concurrent assertion forms for the tokenizer core.
// ----------------------------------------------------------------------------
`ifndef CSV_QUOTED_FIELD_TOKENIZER_CORE_ASSERT_SVH
`define CSV_QUOTED_FIELD_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CSVTOK_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CSVTOK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/csvtok_pkg.sv
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Character codes, token kinds and the transaction and state types.
// ----------------------------------------------------------------------------
package csvtok_pkg;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef enum logic [1:0] {
      KIND_DATA       = 2'd0,
      KIND_FIELD_END  = 2'd1,
      KIND_RECORD_END = 2'd2
   } token_kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      token_kind_type token_kind;
      logic [7:0]     token_byte;
   } rsp_type;

   typedef struct packed {
      logic quoted_mode;
      logic quote_pending;
      logic cr_pending;
      logic field_has_data;
      logic record_has_fields;
   } tok_state_type;

   // Result of one tokenizer step
   typedef struct packed {
      tok_state_type state;
      logic          emit;
      rsp_type       token;
   } step_type;

endpackage

FILE: rtl/core/csvtok_step.sv
// ----------------------------------------------------------------------------
// CSV tokenizer step
// Combinational next state and token for one character or end of input.
// ----------------------------------------------------------------------------
module csvtok_step (
   input  csvtok_pkg::tok_state_type state,
   input  csvtok_pkg::req_type       item,
   output csvtok_pkg::step_type      result
);
   import csvtok_pkg::*;

   logic [7:0] b;
   logic       unq;

   assign b = item.in_byte;

   always_comb begin
      result                  = '0;
      result.state            = state;
      result.token.token_kind = KIND_DATA;
      unq                     = 1'b0;

      if (item.end_of_input) begin
         // Flush a started record, then return to reset
         result.emit             = state.record_has_fields | state.field_has_data;
         result.token.token_kind = KIND_RECORD_END;
         result.state            = '0;
      end else begin
         result.state.cr_pending = 1'b0;
         if (state.quoted_mode) begin
            if (state.quote_pending) begin
               // Decide the held quote: escaped quote or closing quote
               result.state.quote_pending = 1'b0;
               if (b == CH_QUOTE) begin
                  result.state.field_has_data = 1'b1;
                  result.emit                 = 1'b1;
                  result.token.token_byte     = b;
               end else begin
                  result.state.quoted_mode = 1'b0;
                  unq                      = 1'b1;
               end
            end else if (b == CH_QUOTE) begin
               result.state.quote_pending = 1'b1;
            end else begin
               result.state.field_has_data = 1'b1;
               result.emit                 = 1'b1;
               result.token.token_byte     = b;
            end
         end else if (!(state.cr_pending && (b == CH_LF))) begin
            // Drop an LF that follows a record-ending CR
            unq = 1'b1;
         end

         // Unquoted handling of the byte
         if (unq) begin
            priority if (b == CH_QUOTE) begin
               if (!state.field_has_data) begin
                  result.state.quoted_mode = 1'b1;
               end else begin
                  result.emit             = 1'b1;
                  result.token.token_byte = b;
               end
            end else if (b == CH_COMMA) begin
               result.state.field_has_data    = 1'b0;
               result.state.record_has_fields = 1'b1;
               result.emit                    = 1'b1;
               result.token.token_kind        = KIND_FIELD_END;
            end else if ((b == CH_LF) || (b == CH_CR)) begin
               result.state.field_has_data    = 1'b0;
               result.state.record_has_fields = 1'b0;
               result.state.cr_pending        = (b == CH_CR);
               result.emit                    = 1'b1;
               result.token.token_kind        = KIND_RECORD_END;
            end else begin
               result.state.field_has_data = 1'b1;
               result.emit                 = 1'b1;
               result.token.token_byte     = b;
            end
         end
      end
   end

endmodule

FILE: rtl/core/csv_quoted_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// CSV quoted field tokenizer core
// Turns a byte stream into field data, end-of-field and end-of-record tokens.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_data (in_byte, end_of_input)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data (token_kind, token_byte)
//
//  One transaction per cycle sustained while rsp is not stalled; a token goes
//  through the input register and then the result register on its way to rsp.
//  A transaction that yields no token leaves nothing on rsp.
//  Synchronous reset clears the tokenizer flags and both valid registers.
//  A stall on rsp holds the result register and the input register in place.
// ----------------------------------------------------------------------------
module csv_quoted_field_tokenizer_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  csvtok_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output csvtok_pkg::rsp_type rsp_data
);
   import csvtok_pkg::*;
   `include "csv_quoted_field_tokenizer_core_assert.svh"

   logic          in_valid_ff;
   req_type       in_data_ff;
   tok_state_type state_ff;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_data_ff;
   step_type      step;
   logic          advance;

   // Advance the held transaction when the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   csvtok_step u_step (
      .state  (state_ff),
      .item   (in_data_ff),
      .result (step)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Tokenizer flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= step.state;
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance) begin
         out_valid_in = step.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step.emit) begin
         out_data_ff <= step.token;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `CSVTOK_ASSERT_IMPLY(a_pending_in_quotes, clock, reset, state_ff.quote_pending,
      state_ff.quoted_mode, "quote pending outside quoted mode")
   `CSVTOK_ASSERT_NEXT(a_eoi_resets, clock, reset, advance && in_data_ff.end_of_input,
      state_ff == '0, "tokenizer state not cleared after end of input")
   `CSVTOK_ASSERT_IMPLY(a_byte_only_data, clock, reset,
      rsp_valid && (rsp_data.token_kind != KIND_DATA), rsp_data.token_byte == '0,
      "token byte set on a non-data token")
   `CSVTOK_ASSERT_IMPLY(a_rsp_from_advance, clock, reset, $rose(rsp_valid), $past(advance),
      "result appeared without an advancing transaction")
   `CSVTOK_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !in_valid_ff, req_ready,
      "input register empty but not ready")

endmodule

FILE: bench/tb_csv_quoted_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// CSV quoted field tokenizer core testbench
// Drives byte streams into the tokenizer and checks every token against a
// local model of the quoting and line-ending rules. It runs a short directed
// part and then random records and noise. Bursty input, receiver stalls and a
// long receiver hold-off fill the pipeline and stall its input.
// ----------------------------------------------------------------------------
module tb_csv_quoted_field_tokenizer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import csvtok_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 8;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN
   } ready_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Tokenizer model state
   logic quoting     = 1'b0;
   logic quote_seen  = 1'b0;
   logic cr_seen     = 1'b0;
   logic field_open  = 1'b0;
   logic record_open = 1'b0;

   rsp_type        expected_tokens[$];
   rsp_type        predicted_token;
   int             error_count    = 0;
   int             accepted_count = 0;
   int             token_count    = 0;
   int             record_count   = 0;
   int             cycle_count    = 0;
   int             burst_left     = 0;
   int             hold_off_left  = 0;
   bit             sender_idles   = 1'b0;
   ready_mode_type ready_mode     = READY_ALWAYS;
   logic [7:0]     ready_pattern  = 8'b1011_0010;

   csv_quoted_field_tokenizer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Byte handling with quoting off; returns 1 when a token results
   function automatic bit tokenize_unquoted(input logic [7:0] ch, output rsp_type tok);
      tok.token_kind = KIND_DATA;
      tok.token_byte = 8'h00;
      if (ch == CH_QUOTE && !field_open) begin
         quoting = 1'b1;
         return 1'b0;
      end
      if (ch == CH_COMMA) begin
         field_open     = 1'b0;
         record_open    = 1'b1;
         tok.token_kind = KIND_FIELD_END;
         return 1'b1;
      end
      if (ch == CH_LF || ch == CH_CR) begin
         field_open     = 1'b0;
         record_open    = 1'b0;
         cr_seen        = (ch == CH_CR);
         tok.token_kind = KIND_RECORD_END;
         return 1'b1;
      end
      field_open     = 1'b1;
      tok.token_byte = ch;
      return 1'b1;
   endfunction

   // Advance the model by one transaction; returns 1 when a token results
   function automatic bit tokenize_step(input req_type item, output rsp_type tok);
      logic had_cr;
      logic [7:0] ch;
      ch             = item.in_byte;
      tok.token_kind = KIND_DATA;
      tok.token_byte = 8'h00;
      if (item.end_of_input) begin
         had_cr         = record_open || field_open;
         tok.token_kind = KIND_RECORD_END;
         quoting        = 1'b0;
         quote_seen     = 1'b0;
         cr_seen        = 1'b0;
         field_open     = 1'b0;
         record_open    = 1'b0;
         return had_cr;
      end
      had_cr  = cr_seen;
      cr_seen = 1'b0;
      if (quoting) begin
         if (quote_seen) begin
            quote_seen = 1'b0;
            if (ch == CH_QUOTE) begin
               field_open     = 1'b1;
               tok.token_byte = ch;
               return 1'b1;
            end
            // closing quote: the byte is handled outside quotes
            quoting = 1'b0;
            return tokenize_unquoted(ch, tok);
         end
         if (ch == CH_QUOTE) begin
            quote_seen = 1'b1;
            return 1'b0;
         end
         field_open     = 1'b1;
         tok.token_byte = ch;
         return 1'b1;
      end
      // swallow the LF of a CR LF pair
      if (had_cr && ch == CH_LF)
         return 1'b0;
      return tokenize_unquoted(ch, tok);
   endfunction

   // Check each token, then predict from each accepted transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         token_count++;
         if (rsp_data.token_kind == KIND_RECORD_END)
            record_count++;
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none, actual kind %0d byte %h",
                     $time, rsp_data.token_kind, rsp_data.token_byte);
            error_count++;
         end else begin
            predicted_token = expected_tokens.pop_front();
            if (rsp_data.token_kind !== predicted_token.token_kind) begin
               $display("%0t: token_kind mismatch, expected %0d actual %0d",
                        $time, predicted_token.token_kind, rsp_data.token_kind);
               error_count++;
            end
            if (rsp_data.token_byte !== predicted_token.token_byte) begin
               $display("%0t: token_byte mismatch, expected %h actual %h",
                        $time, predicted_token.token_byte, rsp_data.token_byte);
               error_count++;
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         accepted_count++;
         if (tokenize_step(req_data, predicted_token))
            expected_tokens.insert(expected_tokens.size(), predicted_token);
      end
   end

   // Receiver: long hold-off first, otherwise the current stall mode
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            READY_ALWAYS: begin
               rsp_ready <= 1'b1;
            end
            READY_RANDOM: begin
               rsp_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               ready_pattern <= {ready_pattern[6:0], ready_pattern[7]};
               rsp_ready     <= ready_pattern[7];
            end
         endcase
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one transaction and hold it until accepted; gaps fall between bursts
   task automatic send_item(input logic [7:0] ch, input logic eoi);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = sender_idles ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid            <= 1'b1;
      req_data.in_byte      <= ch;
      req_data.end_of_input <= eoi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop offering and hold until every expected token has arrived
   task automatic drain_tokens();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   // Random byte that is not a delimiter; a quote only inside a started field
   function automatic logic [7:0] plain_char(input bit first);
      logic [7:0] ch;
      ch = 8'($urandom_range(0, 255));
      if (ch == CH_COMMA || ch == CH_LF || ch == CH_CR || (first && ch == CH_QUOTE))
         ch = 8'(32'h41 + $urandom_range(0, 25));
      return ch;
   endfunction

   task automatic test_plain_fields();
      send_item(8'h61, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(CH_COMMA, 1'b0);
   endtask

   task automatic test_quoting();
      send_item(CH_QUOTE, 1'b0);    // opens quoting on an empty field
      send_item(CH_QUOTE, 1'b0);
      send_item(CH_QUOTE, 1'b0);    // doubled quote gives one quote
      send_item(CH_CR, 1'b0);       // line ends are data inside quotes
      send_item(CH_LF, 1'b0);
      send_item(CH_QUOTE, 1'b0);
      send_item(8'h7A, 1'b0);       // closes quoting, byte taken as data
   endtask

   task automatic test_line_endings();
      send_item(CH_CR, 1'b0);
      send_item(CH_LF, 1'b0);       // swallowed after CR
      send_item(CH_LF, 1'b0);       // empty line
      send_item(8'h62, 1'b0);
      send_item(CH_QUOTE, 1'b0);    // quote in a non-empty unquoted field
      send_item(CH_QUOTE, 1'b0);
   endtask

   task automatic test_end_of_input();
      send_item(8'h00, 1'b1);       // flush a field with data
      send_item(8'hFF, 1'b1);       // nothing open: no token
      send_item(CH_QUOTE, 1'b0);
      send_item(CH_QUOTE, 1'b0);
      send_item(8'hA5, 1'b1);       // quoted empty field alone: no token
      send_item(CH_QUOTE, 1'b0);
      send_item(8'h71, 1'b0);
      send_item(8'h5A, 1'b1);       // unterminated quoted field is flushed
   endtask

   // One well-formed record with random content, now and then broken
   task automatic send_random_record();
      int fields;
      int len;
      int pick;
      logic [7:0] ch;
      fields = $urandom_range(1, 4);
      for (int f = 0; f < fields; f++) begin
         if ($urandom_range(0, 9) < 4) begin
            send_item(CH_QUOTE, 1'b0);
            len = $urandom_range(0, 5);
            for (int i = 0; i < len; i++) begin
               pick = $urandom_range(0, 9);
               case (pick)
                  0, 1:    ch = CH_QUOTE;
                  2:       ch = CH_COMMA;
                  3:       ch = $urandom_range(0, 1) ? CH_CR : CH_LF;
                  default: ch = 8'($urandom_range(0, 255));
               endcase
               send_item(ch, 1'b0);
               if (ch == CH_QUOTE)
                  send_item(CH_QUOTE, 1'b0);
            end
            // occasionally leave the field unterminated at end of input
            if ($urandom_range(0, 39) == 0) begin
               send_item(8'($urandom_range(0, 255)), 1'b1);
               return;
            end
            send_item(CH_QUOTE, 1'b0);
            if ($urandom_range(0, 9) == 0)
               send_item(plain_char(1'b0), 1'b0);
         end else begin
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++)
               send_item(plain_char(i == 0), 1'b0);
         end
         if (f < fields - 1)
            send_item(CH_COMMA, 1'b0);
      end
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
         send_item(CH_LF, 1'b0);
      end else if (pick < 13) begin
         send_item(CH_CR, 1'b0);
      end else if (pick < 18) begin
         send_item(CH_CR, 1'b0);
         send_item(CH_LF, 1'b0);
      end else begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   task automatic test_random_records(input int item_goal);
      while (accepted_count < item_goal) send_random_record();
   endtask

   // Noise biased towards the special characters
   task automatic test_random_noise(input int count);
      logic [7:0] ch;
      repeat (count) begin
         case ($urandom_range(0, 7))
            0:       ch = CH_QUOTE;
            1:       ch = CH_COMMA;
            2:       ch = CH_CR;
            3:       ch = CH_LF;
            default: ch = 8'($urandom_range(0, 255));
         endcase
         send_item(ch, ($urandom_range(0, 19) == 0));
      end
   endtask

   // Hold the receiver off while the sender keeps offering
   task automatic test_back_pressure();
      hold_off_left = 300;
      sender_idles  = 1'b0;
      repeat (6) send_random_record();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      ready_mode = READY_RANDOM;
      test_plain_fields();
      test_quoting();
      test_line_endings();
      test_end_of_input();
      drain_tokens();

      sender_idles = 1'b1;
      ready_mode   = READY_PATTERN;
      test_random_records(400);
      drain_tokens();

      test_back_pressure();

      sender_idles = 1'b0;
      ready_mode   = READY_ALWAYS;
      test_random_records(650);

      sender_idles = 1'b1;
      ready_mode   = READY_RANDOM;
      test_random_records(950);
      drain_tokens();

      test_random_noise(250);

      // settle: no more tokens may follow
      drain_tokens();
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("Run covered %0d transactions and %0d tokens, %0d of them record ends,",
               accepted_count, token_count, record_count);
      $display("through directed cases, random records, noise, stalls and a long hold-off.");
      if (error_count == 0 && expected_tokens.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: csv_quoted_field_tokenizer_core.f
+incdir+rtl/core
rtl/core/csvtok_pkg.sv
rtl/core/csvtok_step.sv
rtl/core/csv_quoted_field_tokenizer_core.sv
bench/tb_csv_quoted_field_tokenizer_core.sv
